// ===== rtl/keyed_count_table_assert.svh =====
// Assertion macros for the keyed count table RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef KEYED_COUNT_TABLE_ASSERT_SVH
`define KEYED_COUNT_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define KCT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KCT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCT_ASSERT(label, clk, rst, prop, msg)
`define KCT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/kct_pkg.sv =====
// Package for the keyed count table: field widths, entry and result types,
// sequencer states. No dependencies.
`default_nettype none

package kct_pkg;

   localparam int KEY_W               = 16;
   localparam int DELTA_W             = 16;
   localparam int COUNT_W             = 32;
   localparam int SLOT_W              = 4;
   localparam int OCC_W               = 5;
   localparam int DEFAULT_TABLE_DEPTH = 16;

   typedef logic [KEY_W-1:0]          key_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic signed [COUNT_W-1:0] count_type;

   localparam count_type COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
   localparam count_type COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

   typedef struct packed {
      key_type   key;
      count_type count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              found;
      logic              removed;
      logic              rejected_full;
      logic [SLOT_W-1:0] slot;
      count_type         new_count;
      logic [OCC_W-1:0]  occupancy;
   } result_type;

   typedef struct packed {
      key_type   key_a;
      key_type   key_b;
      count_type count;
      delta_type delta;
   } alu_in_type;

   typedef struct packed {
      logic      key_match;
      count_type sum;
      logic      non_positive;
   } alu_out_type;

endpackage

`default_nettype wire

// ===== rtl/kct_req_if.sv =====
// Request channel: valid/ready handshake carrying key and delta.
// Depends on kct_pkg.
`default_nettype none

interface kct_req_if;
   logic                valid;
   logic                ready;
   kct_pkg::key_type    item_key;
   kct_pkg::delta_type  delta;

   modport source (output valid, item_key, delta, input ready);
   modport sink   (input valid, item_key, delta, output ready);
endinterface

`default_nettype wire

// ===== rtl/kct_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the update result.
// Depends on kct_pkg.
`default_nettype none

interface kct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic                            removed;
   logic                            rejected_full;
   logic [kct_pkg::SLOT_W-1:0]      slot;
   kct_pkg::count_type              new_count;
   logic [kct_pkg::OCC_W-1:0]       occupancy;

   modport source (output valid, found, removed, rejected_full, slot, new_count, occupancy,
                   input ready);
   modport sink   (input valid, found, removed, rejected_full, slot, new_count, occupancy,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/kct_alu.sv =====
// Shared compare and saturating add unit of the keyed count table.
// Depends on kct_pkg.
`default_nettype none

module kct_alu (
   input  kct_pkg::alu_in_type  alu_in,
   output kct_pkg::alu_out_type alu_out
);

   localparam int CW = kct_pkg::COUNT_W;
   localparam int DW = kct_pkg::DELTA_W;

   logic [CW:0] wide_a;
   logic [CW:0] wide_b;
   logic [CW:0] wide_sum;
   kct_pkg::count_type sat;

   always_comb begin
      wide_a   = {alu_in.count[CW-1], alu_in.count};
      wide_b   = {{(CW+1-DW){alu_in.delta[DW-1]}}, alu_in.delta};
      wide_sum = wide_a + wide_b;
      if (wide_sum[CW] != wide_sum[CW-1]) begin
         sat = wide_sum[CW] ? kct_pkg::COUNT_MIN : kct_pkg::COUNT_MAX;
      end else begin
         sat = wide_sum[CW-1:0];
      end
   end

   assign alu_out.key_match    = (alu_in.key_a == alu_in.key_b);
   assign alu_out.sum          = sat;
   assign alu_out.non_positive = sat[CW-1] || (sat == '0);

endmodule

`default_nettype wire

// ===== rtl/kct_store.sv =====
// Entry memory of the keyed count table: one write port, one registered read port.
// Depends on kct_pkg.
`default_nettype none

module kct_store #(
   parameter int TABLE_DEPTH = kct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
   input  kct_pkg::entry_type                wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
   output kct_pkg::entry_type                rd_data
);

   kct_pkg::entry_type mem_ff [TABLE_DEPTH];
   kct_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/kct_seq.sv =====
// Sequencer of the keyed count table: linear search, update, append (or reject when full) and
// shift-down on removal. Depends on kct_pkg and keyed_count_table_assert.svh.
`default_nettype none
`include "keyed_count_table_assert.svh"

module kct_seq #(
   parameter int TABLE_DEPTH = kct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  kct_pkg::key_type                  req_key,
   input  kct_pkg::delta_type                req_delta,
   input  logic                              out_free,
   output logic                              res_valid,
   output kct_pkg::result_type               res,
   output logic                              wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
   output kct_pkg::entry_type                wr_data,
   output logic                              rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
   input  kct_pkg::entry_type                rd_data,
   output kct_pkg::alu_in_type               alu_in,
   input  kct_pkg::alu_out_type              alu_out
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   kct_pkg::state_type state_ff, state_in;
   kct_pkg::key_type   key_ff, key_in;
   kct_pkg::delta_type delta_ff, delta_in;
   kct_pkg::count_type cnt_ff, cnt_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               found_ff, found_in;
   logic               removed_ff, removed_in;
   logic               rejected_ff, rejected_in;
   logic [CNT_W-1:0]   idx_dec;
   logic               at_end;

   assign idx_dec = idx_ff - 1'b1;
   assign at_end  = (idx_ff == used_ff);

   assign alu_in.key_a = key_ff;
   assign alu_in.key_b = rd_data.key;
   assign alu_in.delta = delta_ff;
   assign alu_in.count = (state_ff == kct_pkg::ST_CHECK) ? rd_data.count : '0;

   assign rd_addr = idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kct_pkg::ST_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      delta_ff    <= delta_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      found_ff    <= found_in;
      removed_ff  <= removed_in;
      rejected_ff <= rejected_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kct_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kct_pkg::ST_READ;
            end
         end
         kct_pkg::ST_READ: begin
            state_in = at_end ? kct_pkg::ST_DONE : kct_pkg::ST_CHECK;
         end
         kct_pkg::ST_CHECK: begin
            if (alu_out.key_match) begin
               state_in = alu_out.non_positive ? kct_pkg::ST_SHIFT_RD : kct_pkg::ST_DONE;
            end else begin
               state_in = kct_pkg::ST_READ;
            end
         end
         kct_pkg::ST_SHIFT_RD: begin
            state_in = at_end ? kct_pkg::ST_DONE : kct_pkg::ST_SHIFT_WR;
         end
         kct_pkg::ST_SHIFT_WR: begin
            state_in = kct_pkg::ST_SHIFT_RD;
         end
         kct_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = kct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kct_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      key_in      = key_ff;
      delta_in    = delta_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      used_in     = used_ff;
      slot_in     = slot_ff;
      found_in    = found_ff;
      removed_in  = removed_ff;
      rejected_in = rejected_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_data     = '{key: key_ff, count: alu_out.sum};
      unique case (state_ff)
         kct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in      = req_key;
               delta_in    = req_delta;
               idx_in      = '0;
               cnt_in      = '0;
               slot_in     = '0;
               found_in    = 1'b0;
               removed_in  = 1'b0;
               rejected_in = 1'b0;
            end
         end
         kct_pkg::ST_READ: begin
            if (at_end) begin
               if (used_ff < DEPTH_CNT) begin
                  wr_en   = 1'b1;
                  slot_in = idx_ff[IDX_W-1:0];
                  cnt_in  = alu_out.sum;
                  used_in = used_ff + 1'b1;
               end else begin
                  rejected_in = 1'b1;
               end
            end else begin
               rd_en = 1'b1;
            end
         end
         kct_pkg::ST_CHECK: begin
            idx_in = idx_ff + 1'b1;
            if (alu_out.key_match) begin
               found_in = 1'b1;
               slot_in  = idx_ff[IDX_W-1:0];
               cnt_in   = alu_out.sum;
               if (alu_out.non_positive) begin
                  removed_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         kct_pkg::ST_SHIFT_RD: begin
            if (at_end) begin
               used_in = used_ff - 1'b1;
            end else begin
               rd_en = 1'b1;
            end
         end
         kct_pkg::ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_dec[IDX_W-1:0];
            wr_data = rd_data;
            idx_in  = idx_ff + 1'b1;
         end
         kct_pkg::ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   assign res.found         = found_ff;
   assign res.removed       = removed_ff;
   assign res.rejected_full = rejected_ff;
   assign res.slot          = kct_pkg::SLOT_W'(slot_ff);
   assign res.new_count     = cnt_ff;
   assign res.occupancy     = kct_pkg::OCC_W'(used_ff);

   `KCT_ASSERT_NR(a_reset_clears, clock, reset |=> state_ff == kct_pkg::ST_IDLE && used_ff == '0, "reset did not clear sequencer")
   `KCT_ASSERT(a_accept_scan, clock, reset, req_valid && req_ready |=> state_ff == kct_pkg::ST_READ && idx_ff == '0, "search did not start at slot zero")
   `KCT_ASSERT(a_used_bound, clock, reset, used_ff <= DEPTH_CNT, "occupancy above table depth")
   `KCT_ASSERT(a_check_range, clock, reset, state_ff == kct_pkg::ST_CHECK |-> idx_ff < used_ff, "compare beyond occupied entries")
   `KCT_ASSERT(a_remove_shrinks, clock, reset, state_ff == kct_pkg::ST_SHIFT_RD && at_end |=> used_ff == $past(used_ff) - 1'b1, "removal did not shrink table")

endmodule

`default_nettype wire

// ===== rtl/keyed_count_table.sv =====
// Keyed count table: a packed table of key/count pairs searched one entry at
// a time. Each entry is read through the single read port of the entry memory
// and compared in the shared compare/add unit; a miss appends the key after the
// occupied entries unless the table is full. When the hit entry is removed, the
// later entries move down one slot. The store is not cleared; only occupied
// slots are read. One request is in flight at a time; the response register lets
// the next request in while a response waits. Depends on kct_pkg, kct_req_if,
// kct_rsp_if, kct_alu, kct_store and kct_seq.
`default_nettype none

module keyed_count_table #(
   parameter int TABLE_DEPTH = kct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   kct_req_if.sink      req_chan,
   kct_rsp_if.source    rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic                    out_free;
   logic                    res_valid;
   kct_pkg::result_type     res;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   kct_pkg::entry_type      wr_data;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   kct_pkg::entry_type      rd_data;
   kct_pkg::alu_in_type     alu_in;
   kct_pkg::alu_out_type    alu_out;
   logic                    rsp_valid_ff;
   kct_pkg::result_type     rsp_data_ff;

   kct_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_key   (req_chan.item_key),
      .req_delta (req_chan.delta),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .alu_in    (alu_in),
      .alu_out   (alu_out)
   );

   kct_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kct_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_free) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = rsp_data_ff.found;
   assign rsp_chan.removed       = rsp_data_ff.removed;
   assign rsp_chan.rejected_full = rsp_data_ff.rejected_full;
   assign rsp_chan.slot          = rsp_data_ff.slot;
   assign rsp_chan.new_count     = rsp_data_ff.new_count;
   assign rsp_chan.occupancy     = rsp_data_ff.occupancy;

endmodule

`default_nettype wire

// ===== test/tb_keyed_count_table.sv =====
`timescale 1ns / 1ps
// Testbench for keyed_count_table: directed and random key/delta requests,
// responses checked against an in-bench table predictor under random stalls.
// Depends on kct_pkg, kct_req_if, kct_rsp_if and the keyed_count_table RTL.

module tb;

   localparam int TABLE_DEPTH   = kct_pkg::DEFAULT_TABLE_DEPTH;
   localparam int SEGMENT_ITEMS = 250;
   localparam int NUM_SEGMENTS  = 6;
   localparam int HOLD_OFF_LONG = 400;
   localparam int RAMP_ITEMS    = 10;
   localparam int POOL_SIZE     = 20;
   localparam int SETTLE_CYCLES = 80;
   localparam int REPORT_LIMIT  = 10;

   class count_table_tracker;
      kct_pkg::key_type    held_keys[$];
      kct_pkg::count_type  held_counts[$];
      kct_pkg::result_type pending_results[$];
      int                  mismatches;
      int                  failures;

      function void note_request(kct_pkg::key_type key, kct_pkg::delta_type delta);
         kct_pkg::result_type want;
         int                  hit;
         longint              total;
         want = '0;
         hit  = -1;
         for (int i = 0; i < held_keys.size(); i++) begin
            if (held_keys[i] == key) begin
               hit = i;
               break;
            end
         end
         if (hit >= 0) begin
            total = longint'(held_counts[hit]) + longint'(delta);
            if (total > longint'(kct_pkg::COUNT_MAX)) total = longint'(kct_pkg::COUNT_MAX);
            if (total < longint'(kct_pkg::COUNT_MIN)) total = longint'(kct_pkg::COUNT_MIN);
            want.found     = 1'b1;
            want.slot      = kct_pkg::SLOT_W'(hit);
            want.new_count = kct_pkg::count_type'(total);
            if (total <= 0) begin
               held_keys.delete(hit);
               held_counts.delete(hit);
               want.removed = 1'b1;
            end else begin
               held_counts[hit] = kct_pkg::count_type'(total);
            end
         end else if (held_keys.size() < TABLE_DEPTH) begin
            want.slot      = kct_pkg::SLOT_W'(held_keys.size());
            want.new_count = kct_pkg::count_type'(delta);
            held_keys.push_back(key);
            held_counts.push_back(kct_pkg::count_type'(delta));
         end else begin
            want.rejected_full = 1'b1;
         end
         want.occupancy = kct_pkg::OCC_W'(held_keys.size());
         pending_results.push_back(want);
      endfunction

      function void compare_field(string name, logic [kct_pkg::COUNT_W-1:0] want,
                                  logic [kct_pkg::COUNT_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            failures++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
         end
      endfunction

      function void check_response(kct_pkg::result_type got);
         kct_pkg::result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t response with none expected: %p", $realtime, got);
            return;
         end
         want = pending_results.pop_front();
         compare_field("found", kct_pkg::COUNT_W'(want.found), kct_pkg::COUNT_W'(got.found));
         compare_field("removed", kct_pkg::COUNT_W'(want.removed),
                       kct_pkg::COUNT_W'(got.removed));
         compare_field("rejected_full", kct_pkg::COUNT_W'(want.rejected_full),
                       kct_pkg::COUNT_W'(got.rejected_full));
         compare_field("slot", kct_pkg::COUNT_W'(want.slot), kct_pkg::COUNT_W'(got.slot));
         compare_field("new_count", want.new_count, got.new_count);
         compare_field("occupancy", kct_pkg::COUNT_W'(want.occupancy),
                       kct_pkg::COUNT_W'(got.occupancy));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   kct_req_if req_chan();
   kct_rsp_if rsp_chan();

   keyed_count_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   count_table_tracker tracker = new;

   bit               sender_idle;
   bit               receiver_idle;
   int               hold_off_cycles;
   int               stall_left;
   kct_pkg::key_type key_pool[POOL_SIZE];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // response monitor
   always @(posedge clock) begin
      kct_pkg::result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.found         = rsp_chan.found;
         got.removed       = rsp_chan.removed;
         got.rejected_full = rsp_chan.rejected_full;
         got.slot          = rsp_chan.slot;
         got.new_count     = rsp_chan.new_count;
         got.occupancy     = rsp_chan.occupancy;
         tracker.check_response(got);
      end
   end

   // response ready: a long hold-off when one is set, else random stall bursts while receiver_idle is set
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input kct_pkg::key_type key, input kct_pkg::delta_type delta);
      int gap;
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.item_key <= key;
      req_chan.delta    <= delta;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_request(key, delta);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic kct_pkg::key_type pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (tracker.held_keys.size() != 0 && r < 55)
         return tracker.held_keys[$urandom_range(0, tracker.held_keys.size() - 1)];
      if (r < 88)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return kct_pkg::key_type'($urandom);
   endfunction

   function automatic kct_pkg::delta_type pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return kct_pkg::delta_type'($urandom_range(1, 2000));
      if (r < 77) return kct_pkg::delta_type'(-int'($urandom_range(1, 3000)));
      if (r < 85) return '0;
      if (r < 90) return kct_pkg::delta_type'(32767);
      if (r < 95) return kct_pkg::delta_type'(-32768);
      return kct_pkg::delta_type'($urandom);
   endfunction

   task automatic run_directed();
      send_request(16'h0000, 16'sh7FFF);
      send_request(16'hFFFF, 16'sh8000);
      send_request(16'hFFFF, 16'sh0001);
      send_request(16'h0000, 16'sh0000);
      send_request(16'h1234, 16'sh0000);
      send_request(16'h1234, 16'sh0000);
      for (int i = 1; i < TABLE_DEPTH; i++)
         send_request(kct_pkg::key_type'(16'h5A00 + i), kct_pkg::delta_type'(i * 1000));
      send_request(16'hBEEF, 16'sh0005);
      send_request(16'h5A07, 16'sh8000);
      send_request(16'h0000, 16'sh8000);
      send_request(16'h5A0F, 16'sh0064);
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.item_key  <= '0;
      req_chan.delta     <= '0;
      sender_idle        = 1'b1;
      receiver_idle      = 1'b1;
      hold_off_cycles    = 0;
      stall_left         = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         foreach (key_pool[i]) key_pool[i] = kct_pkg::key_type'($urandom);
         case (seg)
            0: begin
               sender_idle     = 1'b0;
               receiver_idle   = 1'b1;
               hold_off_cycles = HOLD_OFF_LONG;
            end
            1: begin
               sender_idle   = 1'b1;
               receiver_idle = 1'b1;
            end
            2: begin
               sender_idle   = 1'b1;
               receiver_idle = 1'b0;
            end
            3: begin
               sender_idle   = 1'b0;
               receiver_idle = 1'b1;
            end
            4: begin
               sender_idle   = 1'b0;
               receiver_idle = 1'b0;
            end
            default: begin
               sender_idle   = 1'b1;
               receiver_idle = 1'b1;
            end
         endcase
         for (int n = 0; n < SEGMENT_ITEMS; n++)
            send_request(pick_key(), pick_delta());
         wait_drained();
      end

      // empty the table, then ramp one key at slot 0 to a large count
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      while (tracker.held_keys.size() != 0)
         send_request(tracker.held_keys[0], 16'sh8000);
      begin
         kct_pkg::key_type ramp_key;
         ramp_key = kct_pkg::key_type'($urandom);
         for (int n = 0; n < RAMP_ITEMS; n++)
            send_request(ramp_key, 16'sh7FFF);
         send_request(ramp_key, 16'sh8000);
         send_request(ramp_key, 16'sh7FFF);
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.failures == 0 && tracker.pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== keyed_count_table.f =====
+incdir+rtl
rtl/kct_pkg.sv
rtl/kct_req_if.sv
rtl/kct_rsp_if.sv
rtl/kct_alu.sv
rtl/kct_store.sv
rtl/kct_seq.sv
rtl/keyed_count_table.sv
test/tb_keyed_count_table.sv
